### rtl/spcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package spcd_pkg;

    // Operand widths of the shared serial divider.
    localparam int DIVIDEND_W = 40;
    localparam int DIVISOR_W  = 17;
    localparam int DIV_CNT_W  = 6;

    // Field and register widths.
    localparam int CAPTURE_W = 16;
    localparam int PERIOD_W  = 17;
    localparam int FACTOR_W  = 24;
    localparam int BASE_W    = 20;
    localparam int STEP_W    = 16;
    localparam int LASTDIV_W = 6;
    localparam int CODE_W    = 8;
    localparam int SCALED_W  = 31;
    localparam int CENTER_W  = 23;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 24;

    // Arithmetic constants.
    localparam logic [FACTOR_W-1:0]   FACTOR_NUM    = 24'd10000000;
    localparam logic [FACTOR_W-1:0]   FACTOR_SAT    = 24'hFFFFFF;
    localparam logic [DIVISOR_W-1:0]  SCALE_DIV     = 17'd1000;
    localparam logic [DIVISOR_W-1:0]  FILTER_DIV    = 17'd10;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BASE_CENTER    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIVISION_STEP  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_DIVISION  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNDEFINED_CODE = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FACTOR_MIN     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FACTOR_MAX     = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN      = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX      = 4'd7;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_FILT_DIV,
        S_COUNT,
        S_FACT_DIV,
        S_CHECK,
        S_MUL,
        S_SCALE_DIV,
        S_MATCH,
        S_CONFIRM,
        S_OUT
    } t_state;

endpackage
`default_nettype wire

### rtl/spcd_divider.sv
`timescale 1ns / 1ps
`default_nettype none
module spcd_divider (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [spcd_pkg::DIVIDEND_W-1:0]   i_dividend,
    input  wire logic [spcd_pkg::DIVISOR_W-1:0]    i_divisor,
    output logic                                   o_done,
    output logic [spcd_pkg::DIVIDEND_W-1:0]        o_quotient
);
    import spcd_pkg::*;

    logic [DIVISOR_W:0]    r_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_div;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [DIVISOR_W:0]    w_trial;
    logic                  w_fits;

    // One quotient bit per cycle: shift in the next dividend bit and subtract if it fits.
    assign w_trial = {r_rem[DIVISOR_W-1:0], r_quo[DIVIDEND_W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
            r_cnt <= DIV_CNT_W'(DIVIDEND_W - 1);
        end else if (r_busy) begin
            r_rem <= w_fits ? (w_trial - {1'b0, r_div}) : w_trial;
            r_quo <= {r_quo[DIVIDEND_W-2:0], w_fits};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

### rtl/spcd_matcher.sv
`timescale 1ns / 1ps
`default_nettype none
module spcd_matcher #(
    parameter int MATCH_TOLERANCE = 10
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [spcd_pkg::SCALED_W-1:0]   i_scaled,
    input  wire logic [spcd_pkg::BASE_W-1:0]     i_base,
    input  wire logic [spcd_pkg::STEP_W-1:0]     i_step,
    input  wire logic [spcd_pkg::LASTDIV_W-1:0]  i_last,
    input  wire logic [spcd_pkg::CODE_W-1:0]     i_undef,
    output logic                                 o_done,
    output logic [spcd_pkg::CODE_W-1:0]          o_code
);
    import spcd_pkg::*;

    localparam int CMP_W = SCALED_W + 2;

    logic [SCALED_W-1:0]  r_v;
    logic [CENTER_W-1:0]  r_center;
    logic [LASTDIV_W-1:0] r_idx;
    logic                 r_busy;
    logic                 r_done;
    logic [CODE_W-1:0]    r_code;
    logic [CMP_W-1:0]     w_v_hi;
    logic [CMP_W-1:0]     w_c_hi;
    logic                 w_hit;

    // Window test for the current division center, one center per cycle.
    assign w_v_hi = CMP_W'(r_v) + CMP_W'(MATCH_TOLERANCE);
    assign w_c_hi = CMP_W'(r_center) + CMP_W'(MATCH_TOLERANCE);
    assign w_hit  = (w_v_hi > CMP_W'(r_center)) && (CMP_W'(r_v) < w_c_hi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (w_hit || r_idx == i_last)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v      <= i_scaled;
            r_center <= CENTER_W'(i_base);
            r_idx    <= '0;
        end else if (r_busy) begin
            if (w_hit) begin
                r_code <= CODE_W'(r_idx);
            end else if (r_idx == i_last) begin
                r_code <= i_undef;
            end else begin
                r_idx    <= r_idx + 1'b1;
                r_center <= r_center + CENTER_W'(i_step);
            end
        end
    end

    assign o_done = r_done;
    assign o_code = r_code;

endmodule
`default_nettype wire

### rtl/servo_pulse_command_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+-----------------------------------
// s        | in        | i_s_tvalid/o_s_tready  | tdata[15:0] capture_value
// m        | out       | o_m_tvalid/i_m_tready  | tdata[0] new_command, [8:1] command,
//          |           |                        | [9] calibrated, [15:10] zero
// cfg      | in        | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data[23:0]
//
// One capture is worked at a time. A calibration capture passes S_COUNT and S_OUT, after
// S_FILT_DIV when the filter update runs on the serial divider; the capture that closes a
// calibration round adds S_FACT_DIV (factor division) and S_CHECK, or S_CHECK alone when
// the filter is zero. A run-phase capture outside the pulse limits passes S_MUL and S_OUT;
// one inside them adds S_SCALE_DIV (40-bit serial division by 1000), S_MATCH (one division
// center per cycle, up to 64) and S_CONFIRM. Reset is synchronous, active low. A new
// capture is taken as soon as the sequencer is idle, even while a result waits on a stalled
// output; the next result then holds the sequencer until the output register frees.
module servo_pulse_command_decoder_core #(
    parameter int CALIB_EVENTS    = 100,
    parameter int MATCH_TOLERANCE = 10,
    parameter int CONFIRM_NEEDED  = 5
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    input  wire logic [15:0]                       i_s_tdata,   // [15:0] capture_value
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic [15:0]                            o_m_tdata,   // new_command, command, calibrated
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [spcd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [spcd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import spcd_pkg::*;

    // Configuration registers.
    logic [BASE_W-1:0]    r_base_center;
    logic [STEP_W-1:0]    r_division_step;
    logic [LASTDIV_W-1:0] r_last_division;
    logic [CODE_W-1:0]    r_undefined_code;
    logic [FACTOR_W-1:0]  r_factor_min;
    logic [FACTOR_W-1:0]  r_factor_max;
    logic [CAPTURE_W-1:0] r_pulse_min;
    logic [CAPTURE_W-1:0] r_pulse_max;

    // Decoder state.
    t_state               r_state, n_state;
    logic [6:0]           r_event_counter;
    logic [CAPTURE_W-1:0] r_first_half;
    logic [PERIOD_W-1:0]  r_period_filter;
    logic                 r_filter_seeded;
    logic                 r_calib_done;
    logic [FACTOR_W-1:0]  r_scale_factor;
    logic [CODE_W-1:0]    r_last_emitted;
    logic [CODE_W-1:0]    r_candidate;
    logic [2:0]           r_confirm_count;
    logic                 r_waiting_change;
    logic [CAPTURE_W-1:0] r_cap;
    logic                 r_emit;
    logic [CODE_W-1:0]    r_code;

    // Output register.
    logic                 r_m_valid;
    logic [15:0]          r_m_data;

    logic                  w_accept;
    logic                  w_cap_in_range;
    logic [PERIOD_W-1:0]   w_period;
    logic [DIVIDEND_W-1:0] w_prod;
    logic [6:0]            w_event_next;
    logic                  w_round_end;
    logic                  w_out_free;
    logic                  div_start;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] div_quotient;
    logic                  mat_start;
    logic                  mat_done;
    logic [CODE_W-1:0]     mat_code;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_cap_in_range = (r_cap > r_pulse_min) && (r_cap < r_pulse_max);
    assign w_period    = PERIOD_W'(i_s_tdata) + PERIOD_W'(r_first_half);
    assign w_prod      = DIVIDEND_W'(r_cap) * DIVIDEND_W'(r_scale_factor);
    assign w_event_next = r_event_counter + 1'b1;
    assign w_round_end = (w_event_next == 7'(CALIB_EVENTS));
    assign w_out_free  = !r_m_valid || i_m_tready;

    // Shared serial divider and division search.
    spcd_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    spcd_matcher #(
        .MATCH_TOLERANCE (MATCH_TOLERANCE)
    ) u_match (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mat_start),
        .i_scaled (div_quotient[SCALED_W-1:0]),
        .i_base   (r_base_center),
        .i_step   (r_division_step),
        .i_last   (r_last_division),
        .i_undef  (r_undefined_code),
        .o_done   (mat_done),
        .o_code   (mat_code)
    );

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (r_calib_done) begin
                        n_state = S_MUL;
                    end else if (r_event_counter[0] && r_filter_seeded) begin
                        n_state = S_FILT_DIV;
                    end else begin
                        n_state = S_COUNT;
                    end
                end
            end
            S_FILT_DIV:  if (div_done) n_state = S_COUNT;
            S_COUNT: begin
                if (!w_round_end) begin
                    n_state = S_OUT;
                end else if (r_period_filter == '0) begin
                    n_state = S_CHECK;
                end else begin
                    n_state = S_FACT_DIV;
                end
            end
            S_FACT_DIV:  if (div_done) n_state = S_CHECK;
            S_CHECK:     n_state = S_OUT;
            S_MUL:       n_state = w_cap_in_range ? S_SCALE_DIV : S_OUT;
            S_SCALE_DIV: if (div_done) n_state = S_MATCH;
            S_MATCH:     if (mat_done) n_state = S_CONFIRM;
            S_CONFIRM:   n_state = S_OUT;
            S_OUT:       if (w_out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // Unit starts and divider operands.
    always_comb begin
        div_start    = 1'b0;
        div_dividend = DIVIDEND_W'(r_period_filter) * DIVIDEND_W'(9) + DIVIDEND_W'(w_period);
        div_divisor  = FILTER_DIV;
        mat_start    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                div_start = w_accept && !r_calib_done && r_event_counter[0] && r_filter_seeded;
            end
            S_COUNT: begin
                div_start    = w_round_end && (r_period_filter != '0);
                div_dividend = DIVIDEND_W'(FACTOR_NUM);
                div_divisor  = r_period_filter;
            end
            S_MUL: begin
                div_start    = w_cap_in_range;
                div_dividend = w_prod;
                div_divisor  = SCALE_DIV;
            end
            S_SCALE_DIV: begin
                mat_start = div_done;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_center    <= 20'd300;
            r_division_step  <= 16'd50;
            r_last_division  <= 6'd10;
            r_undefined_code <= 8'd255;
            r_factor_min     <= 24'd400;
            r_factor_max     <= 24'd600;
            r_pulse_min      <= 16'd100;
            r_pulse_max      <= 16'd4000;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_BASE_CENTER:    r_base_center    <= i_cfg_data[BASE_W-1:0];
                REG_DIVISION_STEP:  r_division_step  <= i_cfg_data[STEP_W-1:0];
                REG_LAST_DIVISION:  r_last_division  <= i_cfg_data[LASTDIV_W-1:0];
                REG_UNDEFINED_CODE: r_undefined_code <= i_cfg_data[CODE_W-1:0];
                REG_FACTOR_MIN:     r_factor_min     <= i_cfg_data[FACTOR_W-1:0];
                REG_FACTOR_MAX:     r_factor_max     <= i_cfg_data[FACTOR_W-1:0];
                REG_PULSE_MIN:      r_pulse_min      <= i_cfg_data[CAPTURE_W-1:0];
                REG_PULSE_MAX:      r_pulse_max      <= i_cfg_data[CAPTURE_W-1:0];
                default: ;
            endcase
        end
    end

    // Calibration and confirmation state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_event_counter  <= '0;
            r_first_half     <= '0;
            r_period_filter  <= '0;
            r_filter_seeded  <= 1'b0;
            r_calib_done     <= 1'b0;
            r_scale_factor   <= '0;
            r_last_emitted   <= 8'd255;
            r_candidate      <= '0;
            r_confirm_count  <= '0;
            r_waiting_change <= 1'b1;
            r_emit           <= 1'b0;
            r_code           <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_emit <= 1'b0;
                        r_code <= '0;
                        if (!r_calib_done) begin
                            if (!r_event_counter[0]) begin
                                r_first_half <= i_s_tdata;
                            end else if (!r_filter_seeded) begin
                                // A seeded filter of value p smooths to p itself.
                                r_period_filter <= w_period;
                                r_filter_seeded <= 1'b1;
                            end
                        end
                    end
                end
                S_FILT_DIV: begin
                    if (div_done) r_period_filter <= div_quotient[PERIOD_W-1:0];
                end
                S_COUNT: begin
                    r_event_counter <= w_round_end ? 7'd0 : w_event_next;
                    if (w_round_end && r_period_filter == '0) r_scale_factor <= FACTOR_SAT;
                end
                S_FACT_DIV: begin
                    if (div_done) r_scale_factor <= div_quotient[FACTOR_W-1:0];
                end
                S_CHECK: begin
                    if (r_scale_factor > r_factor_min && r_scale_factor < r_factor_max) begin
                        r_calib_done <= 1'b1;
                    end
                end
                S_CONFIRM: begin
                    if (r_waiting_change) begin
                        if (mat_code != r_last_emitted) begin
                            r_waiting_change <= 1'b0;
                            r_candidate      <= mat_code;
                        end
                    end else if (mat_code == r_candidate) begin
                        if (r_confirm_count >= 3'(CONFIRM_NEEDED)) begin
                            r_confirm_count  <= '0;
                            r_last_emitted   <= mat_code;
                            r_waiting_change <= 1'b1;
                            r_emit           <= 1'b1;
                            r_code           <= mat_code;
                        end else begin
                            r_confirm_count <= r_confirm_count + 1'b1;
                        end
                    end else begin
                        r_confirm_count  <= '0;
                        r_waiting_change <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Capture register; the scaling product is formed from it in S_MUL.
    always_ff @(posedge i_clk) begin
        if (w_accept) r_cap <= i_s_tdata;
    end

    // Output register; it loads when empty or when its transaction completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (r_state == S_OUT && w_out_free) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && w_out_free) begin
            r_m_data <= {6'd0, r_calib_done, r_code, r_emit};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    // Calibration never reverts once finished.
    a_calib_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_calib_done |=> r_calib_done)
        else $error("calibration flag fell");

    // An emitted command is only reported as calibrated.
    a_emit_calibrated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[0]) |-> o_m_tdata[9])
        else $error("command emitted before calibration");

    // Confirmation count stays within its limit.
    a_confirm_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_confirm_count <= 3'(CONFIRM_NEEDED))
        else $error("confirmation count overran");

    // The divider start pulse is never asserted back to back.
    a_div_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |=> !div_start)
        else $error("divider started twice");

endmodule
`default_nettype wire
